// ----- design/mltcp_pkg.sv -----
// ----------------------------------------------------------------------------
// mltcp_pkg
// Shared types and constants of the multi-level threshold crossing picker.
// ----------------------------------------------------------------------------
package mltcp_pkg;

  localparam int unsigned LEVELS   = 6;
  localparam int unsigned SURFACES = 10;
  localparam int unsigned QDEPTH   = 4;

  localparam int unsigned LVL_W  = 3;
  localparam int unsigned NUM_W  = 4;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CIDX_W = 3;

  localparam logic [NUM_W-1:0] SURF_LIMIT = NUM_W'(SURFACES);
  localparam logic [LVL_W-1:0] LVL_MAX    = LVL_W'(LEVELS);

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_LEVEL_COUNT = 3'd0,
    REG_THRESHOLD_0 = 3'd1,
    REG_THRESHOLD_1 = 3'd2,
    REG_THRESHOLD_2 = 3'd3,
    REG_THRESHOLD_3 = 3'd4,
    REG_THRESHOLD_4 = 3'd5,
    REG_THRESHOLD_5 = 3'd6,
    REG_TIME_STEP   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               trace_start;
  } in_item_t;

  typedef struct packed {
    logic [LVL_W-1:0]  level;
    logic              is_base;
    logic [NUM_W-1:0]  surface_number;
    logic [IDX_W-1:0]  sample_index;
    logic [TIME_W-1:0] pick_time;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [LVL_W-1:0]               level_count;
    logic [LEVELS-1:0][DATA_W-1:0] threshold;
    logic [DATA_W-1:0]             time_step;
  } cfg_t;

  // all events caused by one sample
  typedef struct packed {
    logic [LEVELS-1:0]             hit;
    logic [LEVELS-1:0]             is_base;
    logic [LEVELS-1:0][NUM_W-1:0]  num;
    logic [IDX_W-1:0]              sample_index;
    logic [TIME_W-1:0]             pick_time;
  } bundle_t;

endpackage

// ----- design/mltcp_eval.sv -----
// ----------------------------------------------------------------------------
// mltcp_eval
// Input register, per-level crossing logic and trace state.
// ----------------------------------------------------------------------------
module mltcp_eval import mltcp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  input  logic     q_full_i,
  output logic     push_o,
  output bundle_t  bundle_o
);

  logic                          inq_valid_q;
  in_item_t                      inq_q;
  logic [LEVELS-1:0]             inside_q, inside_d;
  logic [LEVELS-1:0][NUM_W-1:0]  top_q, top_d;
  logic [LEVELS-1:0][NUM_W-1:0]  base_q, base_d;
  logic [IDX_W-1:0]              cnt_q, cnt_eff;
  logic                          halt_q, halt_d;
  logic [LVL_W-1:0]              lc_eff;
  logic                          stop;
  logic                          fire;

  // active level count, clamped
  assign lc_eff = (cfg_i.level_count > LVL_MAX) ? LVL_MAX : cfg_i.level_count;
  assign cnt_eff = inq_q.trace_start ? '0 : cnt_q;

  // crossing evaluation, levels in order with early halt
  always_comb begin
    inside_d = inq_q.trace_start ? '0 : inside_q;
    top_d    = inq_q.trace_start ? '0 : top_q;
    base_d   = inq_q.trace_start ? '0 : base_q;
    stop     = inq_q.trace_start ? 1'b0 : halt_q;
    bundle_o.hit     = '0;
    bundle_o.is_base = '0;
    bundle_o.num     = '0;
    // index and pick time of this sample
    bundle_o.sample_index = cnt_eff;
    bundle_o.pick_time    = {{(TIME_W-IDX_W){1'b0}}, cnt_eff}
                          * {{(TIME_W-DATA_W){1'b0}}, cfg_i.time_step};
    for (int j = 0; j < LEVELS; j++) begin
      if (!stop && (LVL_W'(j) < lc_eff)) begin
        if (!inside_d[j] && (inq_q.sample >= $signed(cfg_i.threshold[j]))) begin
          bundle_o.hit[j] = 1'b1;
          bundle_o.num[j] = top_d[j];
          top_d[j]        = top_d[j] + 1'b1;
          inside_d[j]     = 1'b1;
        end else if (inside_d[j] && (inq_q.sample < $signed(cfg_i.threshold[j]))) begin
          bundle_o.hit[j]     = 1'b1;
          bundle_o.is_base[j] = 1'b1;
          bundle_o.num[j]     = base_d[j];
          base_d[j]           = base_d[j] + 1'b1;
          inside_d[j]         = 1'b0;
        end
        if ((top_d[j] == SURF_LIMIT) || (base_d[j] == SURF_LIMIT)) begin
          stop = 1'b1;
        end
      end
    end
    halt_d = stop;
  end

  // handshake: a sample without events never waits on the queue
  assign fire       = inq_valid_q && (!(|bundle_o.hit) || !q_full_i);
  assign push_o     = fire && (|bundle_o.hit);
  assign in_ready_o = !inq_valid_q || fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      inq_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      inq_q <= in_item_i;
    end
  end

  // trace state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= '0;
      top_q    <= '0;
      base_q   <= '0;
      cnt_q    <= '0;
      halt_q   <= 1'b0;
    end else if (fire) begin
      inside_q <= inside_d;
      top_q    <= top_d;
      base_q   <= base_d;
      cnt_q    <= cnt_eff + 1'b1;
      halt_q   <= halt_d;
    end
  end

endmodule

// ----- design/mltcp_queue.sv -----
// ----------------------------------------------------------------------------
// mltcp_queue
// Small queue of event bundles, one bundle per sample with crossings.
// ----------------------------------------------------------------------------
module mltcp_queue import mltcp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  output logic    full_o,
  output logic    empty_o,
  input  logic    pop_i,
  output bundle_t head_o
);

  localparam int unsigned PTR_W = $clog2(QDEPTH);

  bundle_t               mem_q [QDEPTH];
  logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]        fill_q;

  assign full_o  = (fill_q == (PTR_W+1)'(QDEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

// ----- design/mltcp_unpack.sv -----
// ----------------------------------------------------------------------------
// mltcp_unpack
// Output register that walks a bundle one event item at a time.
// ----------------------------------------------------------------------------
module mltcp_unpack import mltcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  bundle_t   head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic              hold_q;
  bundle_t           cur_q;
  logic [LEVELS-1:0] mask_q;
  logic [LEVELS-1:0] low_bit;
  logic [LVL_W-1:0]  low_idx;
  logic              is_last;
  logic              done;

  // lowest pending level
  always_comb begin
    low_bit = '0;
    low_idx = '0;
    for (int j = LEVELS - 1; j >= 0; j--) begin
      if (mask_q[j]) begin
        low_bit = '0;
        low_bit[j] = 1'b1;
        low_idx = LVL_W'(j);
      end
    end
  end

  assign is_last = ((mask_q & ~low_bit) == '0);
  assign done    = hold_q && out_ready_i && is_last;
  assign pop_o   = !empty_i && (!hold_q || done);

  // result fields
  assign out_valid_o               = hold_q;
  assign out_item_o.level          = low_idx;
  assign out_item_o.is_base        = cur_q.is_base[low_idx];
  assign out_item_o.surface_number = cur_q.num[low_idx];
  assign out_item_o.sample_index   = cur_q.sample_index;
  assign out_item_o.pick_time      = cur_q.pick_time;
  assign out_item_o.last           = is_last;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      mask_q <= '0;
    end else if (pop_o) begin
      hold_q <= 1'b1;
      mask_q <= head_i.hit;
    end else if (done) begin
      hold_q <= 1'b0;
      mask_q <= '0;
    end else if (hold_q && out_ready_i) begin
      mask_q <= mask_q & ~low_bit;
    end
  end

  // bundle payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

endmodule

// ----- design/multi_level_threshold_crossing_picker_top.sv -----
// ----------------------------------------------------------------------------
// multi_level_threshold_crossing_picker_top
// Picks threshold crossings of trace samples at up to six levels.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the in channel (valid/ready), one item per cycle unless
//   stalled; set trace_start on the first sample of each trace. Each sample
//   may cause up to six event items on the out channel, in level order, one
//   per cycle while out_ready_i is high; last marks each sample's final event.
//   Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i while
//   the block is idle; writes take effect on the next sample.
//   Each event passes the input register, event queue and output register.
//   Throughput: one sample per cycle, as long as the event queue has room;
//   a sample with events needs one free bundle slot in the four-deep queue,
//   and output drains one event per cycle while out_ready_i is high.
//   Reset clears the trace state and the queue and loads level_count = 1,
//   every threshold = 50 and time_step = 1.0 (16 fraction bits).
//   When the receiver stalls, the queue fills and in_ready_o drops only
//   for samples that cause events once it is full.
// ----------------------------------------------------------------------------
module multi_level_threshold_crossing_picker_top import mltcp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  logic    push, pop, full, empty;
  bundle_t push_data, head;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_count <= LVL_W'(1);
      cfg_q.threshold   <= {LEVELS{DATA_W'(50)}};
      cfg_q.time_step   <= DATA_W'(65536);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_LEVEL_COUNT: cfg_q.level_count  <= cfg_data_i[LVL_W-1:0];
        REG_THRESHOLD_0: cfg_q.threshold[0] <= cfg_data_i;
        REG_THRESHOLD_1: cfg_q.threshold[1] <= cfg_data_i;
        REG_THRESHOLD_2: cfg_q.threshold[2] <= cfg_data_i;
        REG_THRESHOLD_3: cfg_q.threshold[3] <= cfg_data_i;
        REG_THRESHOLD_4: cfg_q.threshold[4] <= cfg_data_i;
        REG_THRESHOLD_5: cfg_q.threshold[5] <= cfg_data_i;
        REG_TIME_STEP:   cfg_q.time_step    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mltcp_eval u_eval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (full),
    .push_o     (push),
    .bundle_o   (push_data)
  );

  mltcp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .empty_o     (empty),
    .pop_i       (pop),
    .head_o      (head)
  );

  mltcp_unpack u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- dv/crossing_event_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crossing_event_checker
// Watches the sample, event and register ports of the threshold crossing
// picker, works out the crossing events of every accepted sample and checks
// each event item that leaves the block against the oldest one outstanding.
// ----------------------------------------------------------------------------
module crossing_event_checker import mltcp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  in_item_t          in_item_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  out_item_t         out_item_i,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0] cfg_data_i,
  output int unsigned       pending_o,
  output int unsigned       events_o,
  output int unsigned       halts_o,
  output int unsigned       errors_o
);

  localparam logic [DATA_W-1:0] RST_THRESHOLD = 32'd50;
  localparam logic [DATA_W-1:0] RST_TIME_STEP = 32'h0001_0000;

  // mirror of the register file and the per-trace state
  cfg_t              cfg;
  logic [LEVELS-1:0] in_level;
  logic [NUM_W-1:0]  top_cnt  [LEVELS];
  logic [NUM_W-1:0]  base_cnt [LEVELS];
  logic [IDX_W-1:0]  sample_idx;
  logic              halted;

  out_item_t   expected_picks [$];
  int unsigned events_seen = 0;
  int unsigned halt_count  = 0;
  int unsigned error_count = 0;

  task automatic clear_trace();
    in_level = '0;
    for (int j = 0; j < LEVELS; j++) begin
      top_cnt[j]  = '0;
      base_cnt[j] = '0;
    end
    sample_idx = '0;
    halted     = 1'b0;
  endtask

  // crossings of one sample, level by level, last flag on the final one
  task automatic predict_crossings(input in_item_t it);
    int unsigned       active;
    logic [TIME_W-1:0] t_pick;
    out_item_t         ev;
    out_item_t         held;
    bit                have_ev;
    bit                crossed;
    if (it.trace_start) clear_trace();
    t_pick  = TIME_W'(sample_idx) * TIME_W'(cfg.time_step);
    active  = (cfg.level_count > LVL_MAX) ? LEVELS : cfg.level_count;
    have_ev = 1'b0;
    if (!halted) begin
      for (int j = 0; j < active; j++) begin
        crossed         = 1'b1;
        ev.level        = LVL_W'(j);
        ev.sample_index = sample_idx;
        ev.pick_time    = t_pick;
        ev.last         = 1'b0;
        if (!in_level[j] && $signed(it.sample) >= $signed(cfg.threshold[j])) begin
          ev.is_base        = 1'b0;
          ev.surface_number = top_cnt[j];
          top_cnt[j]        = top_cnt[j] + 1'b1;
          in_level[j]       = 1'b1;
        end else if (in_level[j] && $signed(it.sample) < $signed(cfg.threshold[j])) begin
          ev.is_base        = 1'b1;
          ev.surface_number = base_cnt[j];
          base_cnt[j]       = base_cnt[j] + 1'b1;
          in_level[j]       = 1'b0;
        end else begin
          crossed = 1'b0;
        end
        if (crossed) begin
          if (have_ev) expected_picks.push_back(held);
          held    = ev;
          have_ev = 1'b1;
        end
        // surface limit stops the rest of the trace, later levels included
        if (top_cnt[j] == SURF_LIMIT || base_cnt[j] == SURF_LIMIT) begin
          halted = 1'b1;
          halt_count++;
          break;
        end
      end
    end
    if (have_ev) begin
      held.last = 1'b1;
      expected_picks.push_back(held);
    end
    sample_idx = sample_idx + 1'b1;
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  task automatic check_pick(input out_item_t got);
    out_item_t want;
    if (expected_picks.size() == 0) begin
      $error("event item with no crossing outstanding: level %0d sample_index %0d",
             got.level, got.sample_index);
      error_count++;
    end else begin
      want = expected_picks.pop_front();
      events_seen++;
      check_field("level", want.level, got.level);
      check_field("is_base", want.is_base, got.is_base);
      check_field("surface_number", want.surface_number, got.surface_number);
      check_field("sample_index", want.sample_index, got.sample_index);
      check_field("pick_time", want.pick_time, got.pick_time);
      check_field("last", want.last, got.last);
    end
  endtask

  // register writes, then samples, then event items, all at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.level_count = 3'd1;
      for (int j = 0; j < LEVELS; j++) cfg.threshold[j] = RST_THRESHOLD;
      cfg.time_step = RST_TIME_STEP;
      clear_trace();
      expected_picks.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LEVEL_COUNT: cfg.level_count = cfg_data_i[LVL_W-1:0];
          REG_TIME_STEP:   cfg.time_step   = cfg_data_i;
          default:         cfg.threshold[cfg_index_i - REG_THRESHOLD_0] = cfg_data_i;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_crossings(in_item_i);
      if (out_valid_i && out_ready_i) check_pick(out_item_i);
    end
    pending_o <= expected_picks.size();
    events_o  <= events_seen;
    halts_o   <= halt_count;
    errors_o  <= error_count;
  end

endmodule

// ----- dv/tb_multi_level_threshold_crossing_picker_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_level_threshold_crossing_picker_top
// Drives trace samples into the crossing picker under changing level settings,
// with random idling on both channels, a long receiver hold-off and a closing
// trace without idling; the event checker judges the output.
// ----------------------------------------------------------------------------
module tb_multi_level_threshold_crossing_picker_top;
  import mltcp_pkg::*;

  localparam int unsigned SAMPLE_TARGET  = 340;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned TAIL_LEN       = 48;
  localparam longint      S32_MAX        = 64'sd2147483647;
  localparam longint      S32_MIN        = -64'sd2147483648;

  typedef enum logic [1:0] {TRACE_SWING, TRACE_HOVER, TRACE_NOISE} trace_kind_e;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_item   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_item;
  logic              cfg_we    = 1'b0;
  logic [CIDX_W-1:0] cfg_index = REG_LEVEL_COUNT;
  logic [DATA_W-1:0] cfg_data  = '0;

  int unsigned pending;
  int unsigned events_checked;
  int unsigned halted_traces;
  int unsigned error_total;

  cfg_t        now_cfg;
  int unsigned tx_rate      = 0;
  int unsigned rx_rate      = 0;
  int unsigned hold_req     = 0;
  int unsigned hold_ack     = 0;
  int unsigned rx_wait      = 0;
  int unsigned quiet_cycles = 0;
  int unsigned samples_sent = 0;
  int unsigned traces_sent  = 0;

  always #5 clk = ~clk;

  multi_level_threshold_crossing_picker_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  crossing_event_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .events_o    (events_checked),
    .halts_o     (halted_traces),
    .errors_o    (error_total)
  );

  // event receiver: random stall bursts, plus one long hold-off on request
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
      hold_ack  <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      rx_wait   <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_wait > 1) begin
      rx_wait   <= rx_wait - 1;
      out_ready <= 1'b0;
    end else if (rx_rate != 0 && $urandom_range(rx_rate - 1, 0) == 0) begin
      rx_wait   <= $urandom_range(15, 1);
      out_ready <= 1'b0;
    end else begin
      rx_wait   <= 0;
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > S32_MAX) return 32'sh7fff_ffff;
    if (v < S32_MIN) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  // offer one sample, maybe after an idle burst, and wait until taken
  task automatic offer_sample(input logic signed [31:0] s, input logic first);
    if (tx_rate != 0 && $urandom_range(tx_rate - 1, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{sample: s, trace_start: first};
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    if (first) traces_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  // all registers are rewritten once the block has gone quiet
  task automatic load_levels(input cfg_t c);
    wait_drained();
    write_reg(REG_LEVEL_COUNT, {29'($urandom()), c.level_count});
    write_reg(REG_THRESHOLD_0, c.threshold[0]);
    write_reg(REG_THRESHOLD_1, c.threshold[1]);
    write_reg(REG_THRESHOLD_2, c.threshold[2]);
    write_reg(REG_THRESHOLD_3, c.threshold[3]);
    write_reg(REG_THRESHOLD_4, c.threshold[4]);
    write_reg(REG_THRESHOLD_5, c.threshold[5]);
    write_reg(REG_TIME_STEP, c.time_step);
    cfg_we  <= 1'b0;
    now_cfg  = c;
  endtask

  function automatic cfg_t random_levels();
    cfg_t        c;
    longint      centre;
    int unsigned style;
    c.level_count = ($urandom_range(2, 0) == 0) ? 3'($urandom_range(7, 0))
                                                 : 3'($urandom_range(6, 1));
    style  = $urandom_range(3, 0);
    centre = longint'($urandom_range(2000, 0)) - 1000;
    for (int j = 0; j < LEVELS; j++) begin
      case (style)
        0:       c.threshold[j] = $urandom();
        1:       c.threshold[j] = ($urandom_range(1, 0) == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
        default: c.threshold[j] = clamp32(centre + longint'($urandom_range(100, 0)) - 50);
      endcase
    end
    case ($urandom_range(3, 0))
      0:       c.time_step = '0;
      1:       c.time_step = '1;
      2:       c.time_step = 32'h0001_0000;
      default: c.time_step = $urandom();
    endcase
    return c;
  endfunction

  // swing crosses every active level back and forth, hover dithers at one
  function automatic logic signed [31:0] next_sample(input trace_kind_e kind,
                                                    input int unsigned pos);
    longint      lo;
    longint      hi;
    longint      th;
    int unsigned n;
    int unsigned pick;
    n  = (now_cfg.level_count > LVL_MAX) ? LEVELS : now_cfg.level_count;
    lo = S32_MAX;
    hi = S32_MIN;
    for (int j = 0; j < n; j++) begin
      th = longint'($signed(now_cfg.threshold[j]));
      if (th < lo) lo = th;
      if (th > hi) hi = th;
    end
    if (n == 0) begin
      lo = 0;
      hi = 0;
    end
    pick = (n == 0) ? 0 : $urandom_range(n - 1, 0);
    th   = (n == 0) ? 0 : longint'($signed(now_cfg.threshold[pick]));
    case (kind)
      TRACE_SWING: begin
        if ($urandom_range(3, 0) == 0) return clamp32(th + longint'($urandom_range(2, 0)) - 1);
        if (pos % 2 == 0) return clamp32(hi + longint'($urandom_range(20, 0)));
        return clamp32(lo - 1 - longint'($urandom_range(20, 0)));
      end
      TRACE_HOVER: return clamp32(th + longint'($urandom_range(8, 0)) - 4);
      default:     return $urandom();
    endcase
  endfunction

  task automatic play_trace(input trace_kind_e kind, input int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      offer_sample(next_sample(kind, k), k == 0 || $urandom_range(40, 0) == 0);
  endtask

  initial begin
    cfg_t        c;
    trace_kind_e kind;
    int unsigned random_start;
    int unsigned sel;
    now_cfg.level_count = 3'd1;
    for (int j = 0; j < LEVELS; j++) now_cfg.threshold[j] = 32'd50;
    now_cfg.time_step = 32'h0001_0000;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one level at 50, unit time step
    offer_sample(32'sd0, 1'b1);
    offer_sample(32'sd50, 1'b0);
    offer_sample(32'sd49, 1'b0);
    offer_sample(32'sh7fff_ffff, 1'b0);
    offer_sample(32'sh8000_0000, 1'b0);

    // six levels spread over the full range, largest time step
    c.level_count  = 3'd6;
    c.threshold[0] = 32'h8000_0000;
    c.threshold[1] = -32'sd100;
    c.threshold[2] = 32'd0;
    c.threshold[3] = 32'd1;
    c.threshold[4] = 32'd100;
    c.threshold[5] = 32'h7fff_ffff;
    c.time_step    = '1;
    load_levels(c);
    offer_sample(32'sh7fff_ffff, 1'b1);
    offer_sample(32'sh8000_0000, 1'b0);
    offer_sample(32'sd0, 1'b0);
    offer_sample(32'sd1, 1'b0);
    offer_sample(-32'sd101, 1'b0);
    offer_sample(32'sd5, 1'b1);

    // no active level, then a count above the level total
    c.level_count = 3'd0;
    load_levels(c);
    offer_sample(32'sh7fff_ffff, 1'b1);
    offer_sample(32'sh8000_0000, 1'b0);
    c.level_count = 3'd7;
    c.time_step   = '0;
    load_levels(c);
    offer_sample(32'sh7fff_ffff, 1'b1);
    offer_sample(-32'sd1000, 1'b0);
    offer_sample(32'sd100, 1'b0);

    // receiver holds off while swinging samples fill the event queue
    c.time_step = 32'h0001_0000;
    load_levels(c);
    hold_req <= hold_req + 1;
    play_trace(TRACE_SWING, 40);
    wait_drained();

    // random settings and traces with idling on both sides
    random_start = samples_sent;
    while (samples_sent - random_start < SAMPLE_TARGET) begin
      load_levels(random_levels());
      sel     = $urandom_range(3, 0);
      tx_rate = (sel == 0) ? 0 : 2 << sel;
      sel     = $urandom_range(3, 0);
      rx_rate <= (sel == 0) ? 0 : 2 << sel;
      repeat ($urandom_range(3, 1)) begin
        case ($urandom_range(9, 0))
          0, 1:    kind = TRACE_NOISE;
          2, 3, 4: kind = TRACE_HOVER;
          default: kind = TRACE_SWING;
        endcase
        play_trace(kind, $urandom_range(30, 4));
      end
    end

    // closing trace without idling, mostly below the one threshold
    tx_rate = 0;
    rx_rate <= 0;
    c = random_levels();
    c.level_count  = 3'd1;
    c.threshold[0] = '0;
    c.time_step    = '1;
    load_levels(c);
    for (int unsigned k = 0; k < TAIL_LEN; k++)
      offer_sample((k >= TAIL_LEN - 10) ? ((k % 2 == 0) ? 32'sd7 : -32'sd7)
                                        : {1'b1, 31'($urandom())}, k == 0);
    wait_drained();

    $display("covered %0d samples in %0d traces, %0d crossing events checked, %0d halts",
             samples_sent, traces_sent, events_checked, halted_traces);
    $display("level counts 0 to 7, extreme thresholds and steps, back-pressure, surface halts");
    if (error_total == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/mltcp_pkg.sv
design/mltcp_eval.sv
design/mltcp_queue.sv
design/mltcp_unpack.sv
design/multi_level_threshold_crossing_picker_top.sv
dv/crossing_event_checker.sv
dv/tb_multi_level_threshold_crossing_picker_top.sv
